// ----- rtl/alc_pkg.sv -----
package alc_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int VAL_W         = 32;
  localparam int CNT_OUT_W     = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIRST  = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value_in;
  } in_req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] value_out;
    logic [CNT_OUT_W-1:0]    count;
  } out_rsp_t;

endpackage

// ----- rtl/array_list_with_cursor.sv -----
// State path, request accepted to result valid: insert or refused request S_EXEC, S_OUT;
// first/next S_EXEC, S_RDWAIT, S_OUT; remove S_EXEC, S_RDWAIT, an S_SH_RD/S_SH_WR pair per
// later entry shifted down, then S_SH_RD and S_OUT. One request at a time; the sequencer takes
// a new one the cycle after the result is handed to the output register. The remove shift
// uses the separate read port and write port of the entry memory.
// Synchronous active-low reset clears count, cursor and handshake state; entries are not cleared.
module array_list_with_cursor #(
  parameter int DEPTH = alc_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  alc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output alc_pkg::out_rsp_t out_data
);
  import alc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_SH_RD  = 6'b001000,
    S_SH_WR  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              op_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           cur_r, cur_nxt;
  logic                    cur_ok_r, cur_ok_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic                    out_valid_r;
  out_rsp_t                out_r;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    wr_en;

  logic [CW-1:0]           next_idx;
  logic [CW-1:0]           ptr_inc;
  logic                    out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // next position: -1 + 1 = 0 when there is no cursor
  assign next_idx = cur_ok_r ? (CW'(cur_r) + CW'(1)) : '0;
  assign ptr_inc  = CW'(ptr_r) + CW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    cur_ok_nxt  = cur_ok_r;
    ptr_nxt     = ptr_r;
    res_ok_nxt  = res_ok_r;
    res_val_nxt = res_val_r;
    rd_addr     = ptr_r;
    wr_addr     = ptr_r;
    wr_data     = rd_data_r;
    wr_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_ok_nxt  = 1'b0;
        res_val_nxt = '0;
        state_nxt   = S_OUT;
        case (op_r)
          OP_INSERT: begin
            if (count_r < CW'(DEPTH)) begin
              wr_en      = 1'b1;
              wr_addr    = AW'(count_r);
              wr_data    = val_r;
              count_nxt  = count_r + CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          OP_FIRST: begin
            if (count_r != '0) begin
              rd_addr    = '0;
              cur_nxt    = '0;
              cur_ok_nxt = 1'b1;
              res_ok_nxt = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          end
          OP_NEXT: begin
            if (next_idx < count_r) begin
              rd_addr    = AW'(next_idx);
              cur_nxt    = AW'(next_idx);
              cur_ok_nxt = 1'b1;
              res_ok_nxt = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          end
          default: begin
            if (cur_ok_r && (CW'(cur_r) < count_r)) begin
              rd_addr    = cur_r;
              ptr_nxt    = cur_r;
              res_ok_nxt = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        res_val_nxt = rd_data_r;
        state_nxt   = (op_r == OP_REMOVE) ? S_SH_RD : S_OUT;
      end
      S_SH_RD: begin
        if (ptr_inc < count_r) begin
          rd_addr   = AW'(ptr_inc);
          state_nxt = S_SH_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          if (cur_r == '0) begin
            cur_ok_nxt = 1'b0;
          end else begin
            cur_nxt = cur_r - AW'(1);
          end
          state_nxt = S_OUT;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        wr_data   = rd_data_r;
        ptr_nxt   = AW'(ptr_inc);
        state_nxt = S_SH_RD;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      cur_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cur_r    <= cur_nxt;
      cur_ok_r <= cur_ok_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    res_ok_r  <= res_ok_nxt;
    res_val_r <= res_val_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_data.op;
      val_r <= in_data.value_in;
    end
    if (state_r == S_OUT && out_free) begin
      out_r.ok        <= res_ok_r;
      out_r.value_out <= res_val_r;
      out_r.count     <= CNT_OUT_W'(count_r);
    end
  end

endmodule
